[sv/trfr_pkg.sv]
// ----------------------------------------------------------------------------
// Telemetry record FIFO package
// Shared sizes, command and register codes, state type and tag helper.
// ----------------------------------------------------------------------------
package trfr_pkg;

  localparam int FIFO_DEPTH   = 255;
  localparam int RECORD_WORDS = 4;
  localparam int WORD_W       = 32;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_HALF   = CNT_W'(FIFO_DEPTH / 2);
  localparam logic [2:0]       OFF_LAST_W = 3'(RECORD_WORDS);

  // Status word bit positions.
  localparam int STAT_EMPTY_BIT = 24;
  localparam int STAT_FULL_BIT  = 25;
  localparam int STAT_HALF_BIT  = 26;
  localparam int TAG_SHIFT      = 24;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_CTRL = 3'd0;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } trfr_state_t;

  // Tag of record word idx: 1, 2, 4 or 8 in the top byte.
  function automatic logic [WORD_W-1:0] word_tag(input logic [1:0] idx);
    logic [WORD_W-1:0] one;
    one = WORD_W'(1);
    return one << (TAG_SHIFT + int'(idx));
  endfunction

endpackage

[sv/telemetry_record_fifo_regs.sv]
// ----------------------------------------------------------------------------
// Telemetry record FIFO with register bus
// Generator ticks push sequence records; bus writes pop them into a latch.
// ----------------------------------------------------------------------------
// Each input beat is one command: a generator tick, a bus read or a bus write,
// and each gives exactly one result beat (read data and an interrupt pulse).
// Ticks, reads and non-popping writes stay in idle, so one beat can be accepted
// every clock unless the output stalls. A pop (write of 1 to offset 0 with
// entries present) also enters the pop state: the FIFO memory read is registered,
// and the popped record is loaded into the latch there while in_stall stays
// high. The record memory holds only the 32-bit sequence value of each
// record; the four record words are rebuilt from it on a read by adding the
// word tag, so the memory is 32 bits wide and FIFO_DEPTH entries deep. The
// result sits in an output register, so a new beat is taken while the last
// result still waits, provided that output register is free or draining.
module telemetry_record_fifo_regs
  import trfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [2:0]           in_reg_offset,
  input  logic                 in_write_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_read_data,
  output logic                 out_irq_pulse
);

  // Record memory: one sequence value per entry, no reset.
  logic [WORD_W-1:0] store_mem [FIFO_DEPTH];
  logic [WORD_W-1:0] mem_rd_data_r;

  trfr_state_t       state_r, state_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] seq_cnt_r, seq_cnt_nxt;
  logic [WORD_W-1:0] latch_seq_r;
  logic              latch_valid_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_read_data_r, out_read_data_nxt;
  logic              out_irq_r, out_irq_nxt;

  logic              in_accept;
  logic              do_push;
  logic              do_pop;
  logic              latch_load;
  logic [2:0]        word_off;
  logic [WORD_W-1:0] status_word;
  logic [WORD_W-1:0] read_word;

  assign in_accept = in_valid && !in_stall;

  // A push needs room; a pop needs an entry and a write of 1 to control.
  assign do_push = in_accept && (in_cmd == CMD_TICK) && (count_r != CNT_FULL);
  assign do_pop  = in_accept && (in_cmd == CMD_WRITE) && (in_reg_offset == REG_CTRL)
                   && in_write_value && (count_r != '0);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (do_pop) state_nxt = ST_POP;
      ST_POP:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: the pop cycle holds off input and loads the latch.
  always_comb begin
    in_stall   = 1'b0;
    latch_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = out_valid_r && out_stall;
      ST_POP: begin
        in_stall   = 1'b1;
        latch_load = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Pointer, count and sequence counter updates.
  always_comb begin
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    count_nxt   = count_r;
    seq_cnt_nxt = seq_cnt_r;
    if (in_accept && (in_cmd == CMD_TICK)) begin
      seq_cnt_nxt = seq_cnt_r + WORD_W'(1);
    end
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      count_nxt  = count_r + CNT_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      count_nxt  = count_r - CNT_W'(1);
    end
  end

  // Status word and latched record words.
  always_comb begin
    status_word                 = '0;
    status_word[CNT_W-1:0]      = count_r;
    status_word[STAT_EMPTY_BIT] = (count_r == '0);
    status_word[STAT_FULL_BIT]  = (count_r == CNT_FULL);
    status_word[STAT_HALF_BIT]  = (count_r >= CNT_HALF);
  end

  assign word_off = in_reg_offset - 3'd1;

  always_comb begin
    read_word = '0;
    if (in_reg_offset == REG_CTRL) begin
      read_word = status_word;
    end else if ((in_reg_offset <= OFF_LAST_W) && latch_valid_r) begin
      read_word = word_tag(word_off[1:0]) + latch_seq_r;
    end
  end

  always_comb begin
    out_read_data_nxt = '0;
    out_irq_nxt       = 1'b0;
    case (in_cmd)
      CMD_TICK:  out_irq_nxt = do_push && ((count_nxt == CNT_HALF) || (count_nxt == CNT_FULL));
      CMD_READ:  out_read_data_nxt = read_word;
      CMD_WRITE: out_read_data_nxt = '0;
      default:   out_read_data_nxt = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      count_r       <= '0;
      seq_cnt_r     <= '0;
      latch_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      count_r   <= count_nxt;
      seq_cnt_r <= seq_cnt_nxt;
      if (latch_load) latch_valid_r <= 1'b1;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_read_data_r <= out_read_data_nxt;
      out_irq_r       <= out_irq_nxt;
    end
    if (latch_load) latch_seq_r <= mem_rd_data_r;
  end

  // Record memory: write on push, registered read on pop.
  always_ff @(posedge clk) begin
    if (do_push) store_mem[wr_ptr_r] <= seq_cnt_r;
    if (do_pop)  mem_rd_data_r <= store_mem[rd_ptr_r];
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_irq_pulse = out_irq_r;

  // The count never passes the depth and pointers stay inside the memory.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above FIFO depth");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_ptr_r <= PTR_LAST) && (wr_ptr_r <= PTR_LAST))
    else $error("FIFO pointer outside memory");

  // An empty FIFO has its pointers together.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty FIFO with pointers apart");

  // The latch load cycle follows exactly an accepted pop.
  a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (state_r == ST_POP) && in_stall)
    else $error("pop not followed by latch load");

  // Only a push can raise the interrupt.
  a_irq_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !do_push) |=> !out_irq_pulse)
    else $error("interrupt without push");

endmodule
